/* rtl/core/fidp_pkg.sv */
// Package for the firmware image descriptor parser.
// Holds the parse phase codes, the fixed header constants and the parser state type.
// No dependencies.
package fidp_pkg;

  // Parse phase codes
  localparam logic [1:0] PH_IMG  = 2'd0;
  localparam logic [1:0] PH_SEG  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // Fixed image layout
  localparam int          HEADER_BYTES   = 8;
  localparam logic [2:0]  HDR_LAST       = 3'(HEADER_BYTES - 1);
  localparam logic [2:0]  HDR_SEG_TOTAL  = 3'd1;
  localparam logic [2:0]  HDR_LEN_FIRST  = 3'd4;
  localparam logic [2:0]  HDR_LEN_LAST   = 3'd6;
  localparam logic [31:0] DESC_MAGIC     = 32'hABCD5432;

  // Default descriptor size
  localparam int DESC_BYTES_DEF = 256;

  // Parser state, except the capture counter whose width follows the descriptor size
  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  hdr_cnt;
    logic [7:0]  seg_total;
    logic [7:0]  seg_idx;
    logic [31:0] bytes_left;
    logic [23:0] len_asm;
    logic        cap_rejected;
    logic [23:0] magic;
    logic        done;
  } fidp_state_t;

endpackage

/* rtl/core/fidp_if.sv */
// Channel interfaces of the firmware image descriptor parser.
// fidp_in_if carries image bytes, fidp_out_if carries one result per byte.
// No dependencies.
interface fidp_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] data_byte;

  modport source (output valid, output restart, output data_byte, input ready);
  modport sink   (input valid, input restart, input data_byte, output ready);
endinterface

interface fidp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] phase;
  logic       desc_write;
  logic [7:0] desc_offset;
  logic [7:0] desc_byte;
  logic       desc_discard;
  logic       desc_complete;
  logic [7:0] segment_number;

  modport source (output valid, output phase, output desc_write, output desc_offset,
                  output desc_byte, output desc_discard, output desc_complete,
                  output segment_number, input ready);
  modport sink   (input valid, input phase, input desc_write, input desc_offset,
                  input desc_byte, input desc_discard, input desc_complete,
                  input segment_number, output ready);
endinterface

/* rtl/core/firmware_image_descriptor_parser.sv */
// Firmware image descriptor parser: walks image and segment headers, emits descriptor bytes.
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle while the output is not stalled; the parser state updates in a single pass per byte.
// A new byte is taken whenever the output register is empty or being drained.
// Reset (rst, synchronous): image-header phase, all counters and flags cleared.
// Depends on fidp_pkg and fidp_if.
module firmware_image_descriptor_parser #(
  parameter int DESC_BYTES = fidp_pkg::DESC_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fidp_in_if.sink    in_ch,
  fidp_out_if.source out_ch
);
  import fidp_pkg::*;

  localparam int CAP_W = $clog2(DESC_BYTES + 1);
  localparam logic [CAP_W-1:0] CAP_FULL  = CAP_W'(DESC_BYTES);
  localparam logic [CAP_W-1:0] CAP_MAGIC = CAP_W'(3);

  fidp_state_t      st, cur, nxt;
  logic [CAP_W-1:0] cap_cnt, cur_cap, cap_cnt_next;

  logic       in_fire;
  logic       out_valid;
  logic       wr;
  logic [7:0] off;
  logic [7:0] val;
  logic       discard;
  logic       end_seg;

  // Output register frees up when empty or drained this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Per-byte state update
  always_comb begin
    cur          = in_ch.restart ? '0 : st;
    cur_cap      = in_ch.restart ? '0 : cap_cnt;
    nxt          = cur;
    cap_cnt_next = cur_cap;
    wr           = 1'b0;
    off          = 8'd0;
    val          = 8'd0;
    discard      = 1'b0;
    end_seg      = 1'b0;

    case (cur.phase)
      PH_IMG: begin
        if (cur.hdr_cnt == HDR_SEG_TOTAL) nxt.seg_total = in_ch.data_byte;
        if (cur.hdr_cnt == HDR_LAST) begin
          nxt.hdr_cnt = '0;
          nxt.phase   = PH_SEG;
        end else begin
          nxt.hdr_cnt = cur.hdr_cnt + 3'd1;
        end
      end
      PH_SEG: begin
        // length bytes 4..6 go to byte lanes 0..2
        if (cur.hdr_cnt inside {[HDR_LEN_FIRST:HDR_LEN_LAST]})
          nxt.len_asm = cur.len_asm |
                        (24'(in_ch.data_byte) << {cur.hdr_cnt[1:0], 3'b000});
        if (cur.hdr_cnt == HDR_LAST) begin
          nxt.hdr_cnt      = '0;
          nxt.bytes_left   = {in_ch.data_byte, cur.len_asm};
          nxt.len_asm      = '0;
          cap_cnt_next     = '0;
          nxt.cap_rejected = cur.done;
          nxt.magic        = '0;
          nxt.phase        = PH_DATA;
          end_seg          = ({in_ch.data_byte, cur.len_asm} == 32'd0);
        end else begin
          nxt.hdr_cnt = cur.hdr_cnt + 3'd1;
        end
      end
      PH_DATA: begin
        if (!cur.cap_rejected && !cur.done) begin
          wr  = 1'b1;
          off = 8'(cur_cap);
          val = in_ch.data_byte;
          if (cur_cap < CAP_MAGIC)
            nxt.magic = cur.magic |
                        (24'(in_ch.data_byte) << {cur_cap[1:0], 3'b000});
          cap_cnt_next = cur_cap + CAP_W'(1);
          // magic mismatch takes priority over completion
          if (cur_cap == CAP_MAGIC && {in_ch.data_byte, cur.magic} != DESC_MAGIC) begin
            nxt.cap_rejected = 1'b1;
            discard          = 1'b1;
          end else if (cap_cnt_next == CAP_FULL) begin
            nxt.done = 1'b1;
          end
        end
        nxt.bytes_left = cur.bytes_left - 32'd1;
        end_seg        = (nxt.bytes_left == 32'd0);
      end
      default: begin
        // done: byte ignored
      end
    endcase

    // Advance to next segment or finish
    if (end_seg) begin
      nxt.seg_idx = cur.seg_idx + 8'd1;
      nxt.phase   = (nxt.seg_idx >= nxt.seg_total) ? PH_DONE : PH_SEG;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      cap_cnt <= '0;
    end else if (in_fire) begin
      st      <= nxt;
      cap_cnt <= cap_cnt_next;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_ch.phase          <= nxt.phase;
      out_ch.desc_write     <= wr;
      out_ch.desc_offset    <= off;
      out_ch.desc_byte      <= val;
      out_ch.desc_discard   <= discard;
      out_ch.desc_complete  <= nxt.done;
      out_ch.segment_number <= nxt.seg_idx;
    end
  end

  assign out_ch.valid = out_valid;

  // Checks
  a_discard_is_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.desc_discard) |-> out_ch.desc_write)
    else $error("discard without descriptor write");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (st.done && !(in_fire && in_ch.restart)) |=> st.done)
    else $error("descriptor done flag dropped without restart");

  a_cap_bound: assert property (@(posedge clk) disable iff (rst)
    cap_cnt <= CAP_FULL)
    else $error("capture count beyond descriptor size");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_DONE) |-> (st.seg_idx >= st.seg_total))
    else $error("done phase with segments outstanding");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted byte produced no result");

endmodule

/* test/testbench.sv */
// Self-checking testbench for firmware_image_descriptor_parser.
// Streams firmware images (directed, then random images and noise) through the byte channel
// and checks every result against a local parser model. Needs fidp_pkg and fidp_if.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fidp_pkg::*;

  localparam int          DESC_BYTES   = DESC_BYTES_DEF;
  localparam int          STREAM_BYTES = 1650;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  // One input transaction
  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } image_byte_t;

  // One output transaction
  typedef struct packed {
    logic [1:0] phase;
    logic       desc_write;
    logic [7:0] desc_offset;
    logic [7:0] desc_byte;
    logic       desc_discard;
    logic       desc_complete;
    logic [7:0] segment_number;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst;

  fidp_in_if  in_bus ();
  fidp_out_if out_bus ();

  firmware_image_descriptor_parser #(.DESC_BYTES(DESC_BYTES)) u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #2 clk = ~clk;

  image_byte_t   image_bytes[$];
  parse_result_t results_due[$];
  image_byte_t   next_byte;
  parse_result_t want;
  logic          in_taken = 1'b0;
  int            src_gap = 0;
  int            src_steady = 0;
  int            sink_stall = 0;
  int            sink_steady = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   results_checked = 0;
  int unsigned   cycle_count = 0;

  // Parser model state
  fidp_state_t   parser;
  logic [8:0]    capture_cnt;

  function automatic void clear_parser();
    parser      = '0;
    parser.phase = PH_IMG;
    capture_cnt = '0;
  endfunction

  function automatic void close_segment();
    parser.seg_idx = parser.seg_idx + 8'd1;
    parser.phase   = (parser.seg_idx >= parser.seg_total) ? PH_DONE : PH_SEG;
  endfunction

  // Advance the parser model by one byte and return the result it produces
  function automatic parse_result_t parse_image_byte(logic restart, logic [7:0] b);
    parse_result_t r;
    r = '0;
    if (restart) clear_parser();
    case (parser.phase)
      PH_IMG: begin
        if (parser.hdr_cnt == HDR_SEG_TOTAL) parser.seg_total = b;
        if (parser.hdr_cnt == HDR_LAST) begin
          parser.hdr_cnt = '0;
          parser.phase   = PH_SEG;
        end else begin
          parser.hdr_cnt = parser.hdr_cnt + 3'd1;
        end
      end
      PH_SEG: begin
        // length bytes 4..6 are gathered, byte 7 is the top byte
        if (parser.hdr_cnt inside {[HDR_LEN_FIRST:HDR_LEN_LAST]})
          parser.len_asm = parser.len_asm | (24'(b) << (8 * (parser.hdr_cnt - HDR_LEN_FIRST)));
        if (parser.hdr_cnt == HDR_LAST) begin
          parser.hdr_cnt      = '0;
          parser.bytes_left   = {b, parser.len_asm};
          parser.len_asm      = '0;
          capture_cnt         = '0;
          parser.cap_rejected = parser.done;
          parser.magic        = '0;
          parser.phase        = PH_DATA;
          if (parser.bytes_left == 32'd0) close_segment();
        end else begin
          parser.hdr_cnt = parser.hdr_cnt + 3'd1;
        end
      end
      PH_DATA: begin
        if (!parser.cap_rejected && !parser.done) begin
          r.desc_write  = 1'b1;
          r.desc_offset = capture_cnt[7:0];
          r.desc_byte   = b;
          if (capture_cnt < 9'd3)
            parser.magic = parser.magic | (24'(b) << (8 * capture_cnt));
          capture_cnt = capture_cnt + 9'd1;
          // magic mismatch wins over completion on the same byte
          if (capture_cnt == 9'd4 && {b, parser.magic} != DESC_MAGIC) begin
            parser.cap_rejected = 1'b1;
            r.desc_discard      = 1'b1;
          end else if (capture_cnt == 9'(DESC_BYTES)) begin
            parser.done = 1'b1;
          end
        end
        parser.bytes_left = parser.bytes_left - 32'd1;
        if (parser.bytes_left == 32'd0) close_segment();
      end
      default: ;  // done: byte ignored, state kept
    endcase
    r.phase          = parser.phase;
    r.desc_complete  = parser.done;
    r.segment_number = parser.seg_idx;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] exp);
    if (mismatch_count < 100)
      $display("mismatch at result %0d, %s: got %h, expected %h",
               results_checked, field, got, exp);
    mismatch_count++;
  endtask

  // Idle length: mostly none, some short, a few long, with idle-free stretches
  function automatic int next_pause(inout int steady);
    int roll;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      steady = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_byte(logic restart, logic [7:0] value);
    image_byte_t item;
    item.restart = restart;
    item.data    = value;
    image_bytes.push_back(item);
  endfunction

  // Queue one image: header, segments with headers and data; sometimes cut short
  task automatic add_image(bit fill_descriptor);
    int unsigned n_segs, emit, seg_len, data_count, roll;
    logic [31:0] len_word, magic_pattern;
    logic [7:0]  value;
    bit          cut_short;
    roll = $urandom_range(0, 99);
    if (fill_descriptor) n_segs = 2;
    else if (roll < 10) n_segs = 0;
    else if (roll < 85) n_segs = $urandom_range(1, 3);
    else if (roll < 97) n_segs = $urandom_range(4, 8);
    else n_segs = $urandom_range(9, 255);

    for (int i = 0; i < HEADER_BYTES; i++) begin
      if (i == 0) add_byte(fill_descriptor || ($urandom_range(0, 9) != 0), 8'($urandom));
      else if (i == 1) add_byte(1'b0, 8'(n_segs));
      else add_byte(1'b0, 8'($urandom));
    end

    emit = (n_segs == 0) ? 1 : ((n_segs > 10) ? $urandom_range(1, 10) : n_segs);
    for (int s = 0; s < emit; s++) begin
      roll = $urandom_range(0, 99);
      if (fill_descriptor && s == 0) seg_len = $urandom_range(DESC_BYTES, DESC_BYTES + 44);
      else if (roll < 15) seg_len = 0;
      else if (roll < 80) seg_len = $urandom_range(1, 12);
      else if (roll < 95) seg_len = $urandom_range(13, 60);
      else if (roll < 97) seg_len = $urandom_range(DESC_BYTES, DESC_BYTES + 24);
      else seg_len = $urandom;
      len_word = seg_len;
      for (int i = 0; i < 4; i++) add_byte(1'b0, 8'($urandom));
      for (int i = 0; i < 4; i++) add_byte(1'b0, len_word[8*i +: 8]);

      // magic word: correct, one bit off, or random
      roll          = $urandom_range(0, 99);
      magic_pattern = DESC_MAGIC;
      if (!fill_descriptor && roll >= 85) magic_pattern = $urandom;
      else if (!fill_descriptor && roll >= 70)
        magic_pattern = magic_pattern ^ (32'd1 << $urandom_range(0, 31));

      data_count = seg_len;
      cut_short  = 1'b0;
      if (seg_len > 400) begin
        cut_short  = 1'b1;
        data_count = $urandom_range(0, 40);
      end else if (!fill_descriptor && $urandom_range(0, 99) < 4) begin
        cut_short  = 1'b1;
        data_count = $urandom_range(0, seg_len);
      end
      for (int i = 0; i < data_count; i++) begin
        value = (i < 4) ? magic_pattern[8*i +: 8] : 8'($urandom);
        add_byte(1'b0, value);
      end
      if (cut_short) return;
    end
  endtask

  // Driver: next transaction at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (!rst && (!in_bus.valid || in_taken)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_bus.valid <= 1'b0;
      end else if (image_bytes.size() != 0) begin
        next_byte = image_bytes.pop_front();
        in_bus.restart   <= next_byte.restart;
        in_bus.data_byte <= next_byte.data;
        in_bus.valid     <= 1'b1;
        src_gap = next_pause(src_steady);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      sink_stall = next_pause(sink_steady);
    end
  end

  // Monitor: check results first, then predict for the byte taken at this edge
  always @(posedge clk) begin
    in_taken <= !rst && in_bus.valid && in_bus.ready;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with none due", 8'd0, 8'd0);
      end else begin
        want = results_due.pop_front();
        if (out_bus.phase !== want.phase)
          report_mismatch("phase", 8'(out_bus.phase), 8'(want.phase));
        if (out_bus.desc_write !== want.desc_write)
          report_mismatch("desc_write", 8'(out_bus.desc_write), 8'(want.desc_write));
        if (out_bus.desc_offset !== want.desc_offset)
          report_mismatch("desc_offset", out_bus.desc_offset, want.desc_offset);
        if (out_bus.desc_byte !== want.desc_byte)
          report_mismatch("desc_byte", out_bus.desc_byte, want.desc_byte);
        if (out_bus.desc_discard !== want.desc_discard)
          report_mismatch("desc_discard", 8'(out_bus.desc_discard), 8'(want.desc_discard));
        if (out_bus.desc_complete !== want.desc_complete)
          report_mismatch("desc_complete", 8'(out_bus.desc_complete), 8'(want.desc_complete));
        if (out_bus.segment_number !== want.segment_number)
          report_mismatch("segment_number", out_bus.segment_number, want.segment_number);
      end
      results_checked++;
    end
    if (!rst && in_bus.valid && in_bus.ready)
      results_due.push_back(parse_image_byte(in_bus.restart, in_bus.data_byte));
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    in_bus.valid      = 1'b0;
    in_bus.restart    = 1'b0;
    in_bus.data_byte  = 8'h00;
    out_bus.ready     = 1'b0;
    clear_parser();

    // Directed image: zero segment count, one segment of four bytes whose magic
    // is off in the last byte, then bytes in the done phase.
    add_byte(1'b1, 8'h00);
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'hFF);
    add_byte(1'b0, 8'h80);
    add_byte(1'b0, 8'h01);
    add_byte(1'b0, 8'h7F);
    add_byte(1'b0, 8'hAA);
    add_byte(1'b0, 8'h55);
    add_byte(1'b0, 8'hFF);
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'hFF);
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'h04);
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'h00);
    add_byte(1'b0, 8'h32);
    add_byte(1'b0, 8'h54);
    add_byte(1'b0, 8'hCD);
    add_byte(1'b0, 8'hAA);
    add_byte(1'b0, 8'hFF);
    add_byte(1'b0, 8'h00);

    // Random part: one image that completes the descriptor, then a mix of
    // images and noise with scattered restarts
    add_image(1'b1);
    while (image_bytes.size() < STREAM_BYTES) begin
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(4, 30))
          add_byte($urandom_range(0, 99) < 3, 8'($urandom));
      end else begin
        add_image(1'b0);
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (image_bytes.size() != 0 || in_bus.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/fidp_pkg.sv
rtl/core/fidp_if.sv
rtl/core/firmware_image_descriptor_parser.sv
test/testbench.sv
